### hw/rtl/brfb_pkg.sv
`timescale 1ns / 1ps

package brfb_pkg;

  localparam int unsigned DEPTH_DEF     = 4096;
  localparam int unsigned MAX_BURST_DEF = 64;

  localparam int unsigned CAP_W   = 4;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 13;
  localparam int unsigned REQ_W   = 7;

  localparam logic [CAP_W-1:0]   CAP_RESET = 4'd12;
  localparam logic [COUNT_W-1:0] RUN_MAX   = 13'd8191;

  // Request and reply type codes.
  localparam logic REQ_PUSH   = 1'b0;
  localparam logic REQ_POP    = 1'b1;
  localparam logic REPLY_PUSH = 1'b0;
  localparam logic REPLY_POP  = 1'b1;

  typedef struct packed {
    logic               reply_type;
    logic               byte_valid;
    logic [BYTE_W-1:0]  out_byte;
    logic [COUNT_W-1:0] done_count;
    logic               last;
  } res_t;

  // Output queue status seen by the controller.
  typedef struct packed {
    logic [1:0] occ;
    logic       take;
  } q_status_t;

endpackage

### hw/rtl/brfb_in_if.sv
`timescale 1ns / 1ps

interface brfb_in_if import brfb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [BYTE_W-1:0] push_byte;
  logic              push_last;
  logic [REQ_W-1:0]  pop_count;

  modport source (output valid, output req_type, output push_byte, output push_last,
                  output pop_count, input ready);
  modport sink (input valid, input req_type, input push_byte, input push_last,
                input pop_count, output ready);
endinterface

### hw/rtl/brfb_out_if.sv
`timescale 1ns / 1ps

interface brfb_out_if import brfb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               reply_type;
  logic               byte_valid;
  logic [BYTE_W-1:0]  out_byte;
  logic [COUNT_W-1:0] done_count;
  logic               last;

  modport source (output valid, output reply_type, output byte_valid, output out_byte,
                  output done_count, output last, input ready);
  modport sink (input valid, input reply_type, input byte_valid, input out_byte,
                input done_count, input last, output ready);
endinterface

### hw/rtl/brfb_ram.sv
`timescale 1ns / 1ps

module brfb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/brfb_outq.sv
`timescale 1ns / 1ps

module brfb_outq import brfb_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                enq_valid,
  input  res_t                enq_data,
  output q_status_t           status,
  brfb_out_if.source          out_ch
);

  logic [1:0] occ_r, occ_nxt;
  res_t       ent0_r, ent0_nxt;
  res_t       ent1_r, ent1_nxt;
  logic       take;

  assign take = out_ch.valid && out_ch.ready;

  always_comb begin
    occ_nxt  = occ_r;
    ent0_nxt = ent0_r;
    ent1_nxt = ent1_r;
    if (take) begin
      ent0_nxt = ent1_r;
    end
    if (enq_valid && take) begin
      if (occ_r == 2'd1) begin
        ent0_nxt = enq_data;
      end else begin
        ent1_nxt = enq_data;
      end
    end else if (enq_valid) begin
      occ_nxt = occ_r + 2'd1;
      if (occ_r == 2'd0) begin
        ent0_nxt = enq_data;
      end else begin
        ent1_nxt = enq_data;
      end
    end else if (take) begin
      occ_nxt = occ_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 2'd0;
    end else begin
      occ_r <= occ_nxt;
    end
    ent0_r <= ent0_nxt;
    ent1_r <= ent1_nxt;
  end

  assign status.occ  = occ_r;
  assign status.take = take;

  assign out_ch.valid      = (occ_r != 2'd0);
  assign out_ch.reply_type = ent0_r.reply_type;
  assign out_ch.byte_valid = ent0_r.byte_valid;
  assign out_ch.out_byte   = ent0_r.out_byte;
  assign out_ch.done_count = ent0_r.done_count;
  assign out_ch.last       = ent0_r.last;

  // The controller only issues a result when a queue slot is guaranteed.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    enq_valid && !take |-> occ_r != 2'd2)
    else $error("output queue overflow");

  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r != 2'd3)
    else $error("output queue occupancy out of range");

endmodule

### hw/rtl/brfb_ctrl.sv
`timescale 1ns / 1ps

module brfb_ctrl import brfb_pkg::*; #(
  parameter int unsigned DEPTH     = DEPTH_DEF,
  parameter int unsigned MAX_BURST = MAX_BURST_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  brfb_in_if.sink                  in_ch,
  input  logic                     cfg_we,
  input  logic [CAP_W-1:0]         cfg_wdata,
  output logic                     mem_we,
  output logic [$clog2(DEPTH)-1:0] mem_waddr,
  output logic [BYTE_W-1:0]        mem_wdata,
  output logic                     mem_re,
  output logic [$clog2(DEPTH)-1:0] mem_raddr,
  input  logic [BYTE_W-1:0]        mem_rdata,
  input  q_status_t                q_status,
  output logic                     enq_valid,
  output res_t                     enq_data
);

  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned PTR_W  = ADDR_W + 1;
  localparam int unsigned CMP_W  = (PTR_W > REQ_W) ? PTR_W : REQ_W;

  typedef enum logic {ST_IDLE, ST_BURST} state_t;

  state_t             state_r, state_nxt;
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]   size_r, size_nxt;
  logic [COUNT_W-1:0] run_r, run_nxt;
  logic [REQ_W-1:0]   left_r, left_nxt;
  logic [REQ_W-1:0]   total_r, total_nxt;
  logic               s1_valid_r, s1_valid_nxt;
  res_t               s1_meta_r, s1_meta_nxt;

  logic [PTR_W-1:0]  fill;
  logic [ADDR_W-1:0] mask;
  logic              not_full;
  logic [2:0]        slot_sum;
  logic              slot_ok;
  logic              accept;
  logic [REQ_W-1:0]  req_c;
  logic [CMP_W-1:0]  fill_ext, req_ext;
  logic [REQ_W-1:0]  pop_n;

  // Ring size from the capacity code: zero acts as one, and sizes beyond
  // the storage are clamped to the storage depth.
  function automatic logic [PTR_W-1:0] cap_size(input logic [CAP_W-1:0] lg);
    logic [CAP_W-1:0] lg_c;
    lg_c = (lg == '0) ? CAP_W'(1) : lg;
    if (32'(lg_c) > ADDR_W) begin
      lg_c = CAP_W'(ADDR_W);
    end
    return PTR_W'(1) << lg_c;
  endfunction

  assign fill     = wr_ptr_r - rd_ptr_r;
  assign mask     = ADDR_W'(size_r - PTR_W'(1));
  assign not_full = (fill != size_r);

  // A result may enter the pipe when it and everything ahead still fit in
  // the two-entry output queue.
  assign slot_sum = {1'b0, q_status.occ} + {2'b00, s1_valid_r} - {2'b00, q_status.take};
  assign slot_ok  = (slot_sum < 3'd2);

  assign in_ch.ready = (state_r == ST_IDLE) && slot_ok;
  assign accept      = in_ch.valid && in_ch.ready;

  assign req_c    = (32'(in_ch.pop_count) > MAX_BURST) ? REQ_W'(MAX_BURST) : in_ch.pop_count;
  assign fill_ext = CMP_W'(fill);
  assign req_ext  = CMP_W'(req_c);
  assign pop_n    = REQ_W'((fill_ext < req_ext) ? fill_ext : req_ext);

  always_comb begin
    state_nxt    = state_r;
    wr_ptr_nxt   = wr_ptr_r;
    rd_ptr_nxt   = rd_ptr_r;
    size_nxt     = size_r;
    run_nxt      = run_r;
    left_nxt     = left_r;
    total_nxt    = total_r;
    s1_valid_nxt = 1'b0;
    s1_meta_nxt  = s1_meta_r;
    mem_we       = 1'b0;
    mem_re       = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_ch.req_type == REQ_PUSH) begin
          if (not_full) begin
            mem_we     = 1'b1;
            wr_ptr_nxt = wr_ptr_r + PTR_W'(1);
            if (run_r != RUN_MAX) begin
              run_nxt = run_r + COUNT_W'(1);
            end
          end
          if (in_ch.push_last) begin
            s1_valid_nxt           = 1'b1;
            s1_meta_nxt.reply_type = REPLY_PUSH;
            s1_meta_nxt.byte_valid = 1'b0;
            s1_meta_nxt.out_byte   = '0;
            s1_meta_nxt.done_count = run_nxt;
            s1_meta_nxt.last       = 1'b1;
            run_nxt                = '0;
          end
        end else if (accept) begin
          if (pop_n == '0) begin
            s1_valid_nxt           = 1'b1;
            s1_meta_nxt.reply_type = REPLY_POP;
            s1_meta_nxt.byte_valid = 1'b0;
            s1_meta_nxt.out_byte   = '0;
            s1_meta_nxt.done_count = '0;
            s1_meta_nxt.last       = 1'b1;
          end else begin
            state_nxt = ST_BURST;
            left_nxt  = pop_n;
            total_nxt = pop_n;
          end
        end
      end
      ST_BURST: begin
        if (slot_ok) begin
          mem_re                 = 1'b1;
          rd_ptr_nxt             = rd_ptr_r + PTR_W'(1);
          left_nxt               = left_r - REQ_W'(1);
          s1_valid_nxt           = 1'b1;
          s1_meta_nxt.reply_type = REPLY_POP;
          s1_meta_nxt.byte_valid = 1'b1;
          s1_meta_nxt.out_byte   = '0;
          s1_meta_nxt.last       = (left_r == REQ_W'(1));
          s1_meta_nxt.done_count = (left_r == REQ_W'(1)) ? COUNT_W'(total_r) : '0;
          if (left_r == REQ_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // A capacity write re-initializes the ring.
    if (cfg_we) begin
      size_nxt   = cap_size(cfg_wdata);
      wr_ptr_nxt = '0;
      rd_ptr_nxt = '0;
      run_nxt    = '0;
    end
  end

  assign mem_waddr = wr_ptr_r[ADDR_W-1:0] & mask;
  assign mem_wdata = in_ch.push_byte;
  assign mem_raddr = rd_ptr_r[ADDR_W-1:0] & mask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      size_r     <= cap_size(CAP_RESET);
      run_r      <= '0;
      left_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      wr_ptr_r   <= wr_ptr_nxt;
      rd_ptr_r   <= rd_ptr_nxt;
      size_r     <= size_nxt;
      run_r      <= run_nxt;
      left_r     <= left_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
    total_r   <= total_nxt;
    s1_meta_r <= s1_meta_nxt;
  end

  // The stage register meets the memory read data here.
  always_comb begin
    enq_valid = s1_valid_r;
    enq_data  = s1_meta_r;
    if (s1_meta_r.byte_valid) begin
      enq_data.out_byte = mem_rdata;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) <= size_r)
    else $error("fill level exceeds ring size");

  a_no_write_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_BURST |-> !mem_we)
    else $error("ring write during pop burst");

  a_burst_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_BURST |-> left_r != '0 && left_r <= total_r)
    else $error("pop burst counter out of range");

endmodule

### hw/rtl/byte_ring_fifo_burst.sv
`timescale 1ns / 1ps

// Byte FIFO on a power-of-two ring held in one synchronous RAM.
// Input channel in_ch carries requests: a push offers one byte of a run
// (push_last marks its final byte), a pop asks for up to MAX_BURST bytes.
// Output channel out_ch carries results: one summary per push run with the
// count of bytes stored, or the popped bytes of a pop with the delivered
// count on the result marked last; an empty pop yields one zero-count result.
// cfg_we/cfg_wdata write the ring size code (log2 of bytes in use); a write
// empties the ring and must be made only while the block is idle.
// Timing: a push request is taken every cycle while the queue has room; its
// summary passes through the stage register and the output queue. A pop holds
// the controller in its burst state, which reads one byte a cycle while the
// queue has room, set by the single RAM read port.
// Results pass through a two-entry output queue, so a stalled receiver holds
// the current result while the block continues until the queue is full; then
// in_ch.ready drops and pop bursts pause without losing bytes.
// Reset empties the ring and sets the size code to 12, which gives the full
// storage depth at the default DEPTH. The RAM is not cleared; only bytes
// written since the last reset or size write are ever read.

module byte_ring_fifo_burst import brfb_pkg::*; #(
  parameter int unsigned DEPTH     = DEPTH_DEF,
  parameter int unsigned MAX_BURST = MAX_BURST_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  brfb_in_if.sink          in_ch,
  brfb_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);

  localparam int unsigned ADDR_W = $clog2(DEPTH);

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;
  q_status_t         q_status;
  logic              enq_valid;
  res_t              enq_data;

  // Ring storage: written by pushes, read by pop bursts, never both at once.
  brfb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Pointer bookkeeping, request decode and burst sequencing.
  brfb_ctrl #(
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .q_status  (q_status),
    .enq_valid (enq_valid),
    .enq_data  (enq_data)
  );

  // Output queue decouples the receiver's stalls from the controller.
  brfb_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .enq_valid (enq_valid),
    .enq_data  (enq_data),
    .status    (q_status),
    .out_ch    (out_ch)
  );

endmodule
